// ===== sv/rtp_pkg.sv =====
package rtp_pkg;

    localparam int FRAC = 28;
    localparam int IN_W = 32;
    localparam int DIV_W = IN_W + FRAC;
    localparam int DEN_W = IN_W - 1;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
    } point_t;

    typedef struct packed {
        logic signed [31:0] pixel_u;
        logic signed [31:0] pixel_v;
        logic [1:0]         proj_status;
    } pixel_t;

    typedef struct packed {
        logic               sat;
        logic signed [63:0] val;
    } fx_t;

    localparam int FX_W = $bits(fx_t);

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_DEPTH = 2'd1;
    localparam logic [1:0] ST_SAT   = 2'd2;
    localparam logic [1:0] ST_RSVD  = 2'd3;

    localparam logic [2:0] CFG_FOCAL_X  = 3'd0;
    localparam logic [2:0] CFG_FOCAL_Y  = 3'd1;
    localparam logic [2:0] CFG_PRINC    = 3'd2;
    localparam logic [2:0] CFG_K1       = 3'd3;
    localparam logic [2:0] CFG_K2       = 3'd4;
    localparam logic [2:0] CFG_K3       = 3'd5;
    localparam logic [2:0] CFG_P1       = 3'd6;
    localparam logic [2:0] CFG_P2       = 3'd7;

    localparam logic [31:0]        FOCAL_RESET = 32'h0001_0000;
    localparam logic signed [63:0] FX_ONE  = 64'sh0000_0000_1000_0000;
    localparam logic signed [63:0] FX_MAX  = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] FX_MIN  = 64'sh8000_0000_0000_0000;
    localparam logic signed [63:0] I32_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] I32_MIN = 64'shFFFF_FFFF_8000_0000;

    function automatic fx_t fx_add(fx_t a, fx_t b);
        logic [64:0] s;
        fx_t         r;
        s = {a.val[63], a.val} + {b.val[63], b.val};
        r.sat = a.sat | b.sat;
        r.val = s[63:0];
        if (s[64] != s[63])
        begin
            r.sat = 1'b1;
            r.val = s[64] ? FX_MIN : FX_MAX;
        end
        return r;
    endfunction

    function automatic fx_t fx_clamp32(fx_t a);
        fx_t r;
        r = a;
        if ($signed(a.val) > I32_MAX)
        begin
            r.sat = 1'b1;
            r.val = I32_MAX;
        end
        else if ($signed(a.val) < I32_MIN)
        begin
            r.sat = 1'b1;
            r.val = I32_MIN;
        end
        return r;
    endfunction

    function automatic fx_t fx_s32(logic [31:0] v);
        fx_t r;
        r.sat = 1'b0;
        r.val = {{32{v[31]}}, v};
        return r;
    endfunction

    function automatic fx_t fx_u32(logic [31:0] v);
        fx_t r;
        r.sat = 1'b0;
        r.val = {32'd0, v};
        return r;
    endfunction

endpackage

// ===== sv/rtp_if.sv =====
interface rtp_point_if import rtp_pkg::*; ();
    logic   valid;
    logic   ready;
    point_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface rtp_pixel_if import rtp_pkg::*; ();
    logic   valid;
    logic   ready;
    pixel_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface rtp_cfg_if ();
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [63:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== sv/rtp_delay.sv =====
module rtp_delay #(
    parameter int W = 1,
    parameter int DEPTH = 1
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         adv,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    logic [W-1:0] tap_reg [DEPTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                tap_reg[i] <= '0;
            end
        end
        else if (adv)
        begin
            tap_reg[0] <= d;
            for (int i = 1; i < DEPTH; i++)
            begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign q = tap_reg[DEPTH-1];

endmodule

// ===== sv/rtp_div.sv =====
module rtp_div import rtp_pkg::*; (
    input  logic             clk,
    input  logic             adv,
    input  logic [DIV_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [DIV_W-1:0] quo
);

    logic [DEN_W-1:0] rem_reg  [DIV_W-1];
    logic [DEN_W-1:0] den_reg  [DIV_W-1];
    logic [DIV_W-1:0] work_reg [DIV_W];

    for (genvar i = 0; i < DIV_W; i++)
    begin : g_stage
        logic [DEN_W-1:0] rem_in;
        logic [DEN_W-1:0] den_in;
        logic [DIV_W-1:0] work_in;
        logic [DEN_W:0]   trial;
        logic [DEN_W:0]   diff;
        logic             take;

        if (i == 0)
        begin : g_first
            assign rem_in  = '0;
            assign den_in  = den;
            assign work_in = num;
        end
        else
        begin : g_rest
            assign rem_in  = rem_reg[i-1];
            assign den_in  = den_reg[i-1];
            assign work_in = work_reg[i-1];
        end

        assign trial = {rem_in, work_in[DIV_W-1]};
        assign diff  = trial - {1'b0, den_in};
        assign take  = (trial >= {1'b0, den_in});

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                work_reg[i] <= {work_in[DIV_W-2:0], take};
            end
        end

        if (i < DIV_W - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    rem_reg[i] <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                    den_reg[i] <= den_in;
                end
            end
        end
    end

    assign quo = work_reg[DIV_W-1];

endmodule

// ===== sv/rtp_smul.sv =====
module rtp_smul import rtp_pkg::*; (
    input  logic clk,
    input  logic adv,
    input  fx_t  a,
    input  fx_t  b,
    output fx_t  y
);

    logic [63:0]  ua;
    logic [63:0]  ub;
    logic [63:0]  p00_reg, p01_reg, p10_reg, p11_reg;
    logic         neg1_reg, sat1_reg;
    logic [127:0] prod_next, prod_reg;
    logic         neg2_reg, sat2_reg;
    logic [127:0] rnd;
    logic         ovf;
    logic [63:0]  mag;
    fx_t          y_next, y_reg;

    assign ua = a.val[63] ? (~a.val + 64'd1) : a.val;
    assign ub = b.val[63] ? (~b.val + 64'd1) : b.val;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p00_reg  <= ua[31:0]  * ub[31:0];
            p01_reg  <= ua[31:0]  * ub[63:32];
            p10_reg  <= ua[63:32] * ub[31:0];
            p11_reg  <= ua[63:32] * ub[63:32];
            neg1_reg <= a.val[63] ^ b.val[63];
            sat1_reg <= a.sat | b.sat;
        end
    end

    assign prod_next = {64'd0, p00_reg} + {32'd0, p01_reg, 32'd0}
                     + {32'd0, p10_reg, 32'd0} + {p11_reg, 64'd0};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg <= prod_next;
            neg2_reg <= neg1_reg;
            sat2_reg <= sat1_reg;
        end
    end

    always_comb
    begin
        rnd = prod_reg + (128'd1 << (FRAC - 1));
        ovf = |rnd[127:63+FRAC];
        mag = ovf ? FX_MAX : {1'b0, rnd[62+FRAC:FRAC]};
        y_next.sat = ovf | sat2_reg;
        y_next.val = neg2_reg ? (~mag + 64'd1) : mag;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            y_reg <= y_next;
        end
    end

    assign y = y_reg;

endmodule

// ===== sv/radtan_point_projection.sv =====
// Projects camera-frame points (signed Q16.16) through a Brown-Conrady radial and tangential
// lens model to pixel coordinates, one point accepted per clock when the output side keeps
// up. From an accepted point to its result, the path runs through the one-bit-per-stage
// pipelined dividers for x/z and y/z, then the chain of six dependent pipelined multipliers
// and registered saturating adders. A two-entry output buffer lets the pipeline keep
// accepting while a finished result waits. Configuration writes are always taken and act
// on points still in the pipeline that have not yet used the written value, so write only
// while it is empty.
module radtan_point_projection import rtp_pkg::*; (
    input logic         clk,
    input logic         rst_n,
    rtp_point_if.sink   point,
    rtp_pixel_if.source pixel,
    rtp_cfg_if.sink     cfg
);

    logic [31:0] focal_x_reg, focal_y_reg;
    logic [63:0] pp_reg;
    logic [31:0] k1_reg, k2_reg, k3_reg, p1_reg, p2_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focal_x_reg <= FOCAL_RESET;
            focal_y_reg <= FOCAL_RESET;
            pp_reg      <= '0;
            k1_reg      <= '0;
            k2_reg      <= '0;
            k3_reg      <= '0;
            p1_reg      <= '0;
            p2_reg      <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_FOCAL_X: focal_x_reg <= cfg.data[31:0];
                CFG_FOCAL_Y: focal_y_reg <= cfg.data[31:0];
                CFG_PRINC:   pp_reg      <= cfg.data;
                CFG_K1:      k1_reg      <= cfg.data[31:0];
                CFG_K2:      k2_reg      <= cfg.data[31:0];
                CFG_K3:      k3_reg      <= cfg.data[31:0];
                CFG_P1:      p1_reg      <= cfg.data[31:0];
                CFG_P2:      p2_reg      <= cfg.data[31:0];
                default:     focal_x_reg <= focal_x_reg;
            endcase
        end
    end

    logic   adv;
    logic   skid_valid_reg, out_valid_reg;
    pixel_t skid_data_reg, out_data_reg;

    assign adv         = !skid_valid_reg;
    assign point.ready = adv;

    // front end: magnitudes and rounded dividends
    logic [31:0]      ax, ay;
    logic [DIV_W-1:0] num_x, num_y;
    logic             zbad;
    logic [3:0]       flag_in, flag_mid;
    logic [1:0]       flag_end;
    logic [DIV_W-1:0] qx, qy;

    assign ax    = point.data.point_x[31] ? (~point.data.point_x + 32'd1) : point.data.point_x;
    assign ay    = point.data.point_y[31] ? (~point.data.point_y + 32'd1) : point.data.point_y;
    assign num_x = {ax, {FRAC{1'b0}}} + {{(FRAC+2){1'b0}}, point.data.point_z[30:1]};
    assign num_y = {ay, {FRAC{1'b0}}} + {{(FRAC+2){1'b0}}, point.data.point_z[30:1]};
    assign zbad  = point.data.point_z[31] || (point.data.point_z == 32'sd0);
    assign flag_in = {point.valid, zbad, point.data.point_x[31], point.data.point_y[31]};

    rtp_div u_div_x (.clk(clk), .adv(adv), .num(num_x), .den(point.data.point_z[30:0]),
                     .quo(qx));
    rtp_div u_div_y (.clk(clk), .adv(adv), .num(num_y), .den(point.data.point_z[30:0]),
                     .quo(qy));

    rtp_delay #(.W(4), .DEPTH(DIV_W)) u_flag_a (.clk(clk), .rst_n(rst_n), .adv(adv),
        .d(flag_in), .q(flag_mid));
    rtp_delay #(.W(2), .DEPTH(23)) u_flag_b (.clk(clk), .rst_n(rst_n), .adv(adv),
        .d(flag_mid[3:2]), .q(flag_end));

    fx_t xn_next, yn_next, xn_reg, yn_reg;

    always_comb
    begin
        xn_next.sat = 1'b0;
        yn_next.sat = 1'b0;
        xn_next.val = flag_mid[1] ? (~{4'd0, qx} + 64'd1) : {4'd0, qx};
        yn_next.val = flag_mid[0] ? (~{4'd0, qy} + 64'd1) : {4'd0, qy};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            xn_reg <= xn_next;
            yn_reg <= yn_next;
        end
    end

    // coefficients
    fx_t k1e, k2e, k3e, p1e, p2e, p1x2, p2x2, fxe, fye, cxe, cye, one;

    always_comb
    begin
        k1e  = fx_s32(k1_reg);
        k2e  = fx_s32(k2_reg);
        k3e  = fx_s32(k3_reg);
        p1e  = fx_s32(p1_reg);
        p2e  = fx_s32(p2_reg);
        p1x2 = fx_s32(p1_reg);
        p2x2 = fx_s32(p2_reg);
        p1x2.val = {p1e.val[62:0], 1'b0};
        p2x2.val = {p2e.val[62:0], 1'b0};
        fxe  = fx_u32(focal_x_reg);
        fye  = fx_u32(focal_y_reg);
        cxe  = fx_u32(pp_reg[63:32]);
        cye  = fx_u32(pp_reg[31:0]);
        one.sat = 1'b0;
        one.val = FX_ONE;
    end

    fx_t x2, y2, xy;
    fx_t r2_reg, x2d_reg, y2d_reg, txx_reg, tyy_reg;
    fx_t p1xy, p2xy, r4, k1r2, p2t, p1t, fd1_reg, r2_d, r6, k2r4, fd1_d, fd2_reg;
    fx_t k3r6, fd2_d, fd_reg, fd_next, xn_d, yn_d, xnfd, ynfd, p1xy_d, p2xy_d;
    fx_t xd1_reg, yd1_reg, p2t_d, p1t_d, xd_reg, yd_reg, u0, v0;

    rtp_smul u_x2 (.clk(clk), .adv(adv), .a(xn_reg), .b(xn_reg), .y(x2));
    rtp_smul u_y2 (.clk(clk), .adv(adv), .a(yn_reg), .b(yn_reg), .y(y2));
    rtp_smul u_xy (.clk(clk), .adv(adv), .a(xn_reg), .b(yn_reg), .y(xy));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r2_reg  <= fx_add(x2, y2);
            x2d_reg <= fx_add(x2, x2);
            y2d_reg <= fx_add(y2, y2);
            txx_reg <= fx_add(r2_reg, x2d_reg);
            tyy_reg <= fx_add(r2_reg, y2d_reg);
        end
    end

    rtp_smul u_p1xy (.clk(clk), .adv(adv), .a(p1x2), .b(xy), .y(p1xy));
    rtp_smul u_p2xy (.clk(clk), .adv(adv), .a(p2x2), .b(xy), .y(p2xy));
    rtp_smul u_r4   (.clk(clk), .adv(adv), .a(r2_reg), .b(r2_reg), .y(r4));
    rtp_smul u_k1r2 (.clk(clk), .adv(adv), .a(k1e), .b(r2_reg), .y(k1r2));
    rtp_smul u_p2t  (.clk(clk), .adv(adv), .a(p2e), .b(txx_reg), .y(p2t));
    rtp_smul u_p1t  (.clk(clk), .adv(adv), .a(p1e), .b(tyy_reg), .y(p1t));

    rtp_delay #(.W(FX_W), .DEPTH(3)) u_r2_d (.clk(clk), .rst_n(rst_n), .adv(adv),
        .d(r2_reg), .q(r2_d));

    rtp_smul u_r6   (.clk(clk), .adv(adv), .a(r4), .b(r2_d), .y(r6));
    rtp_smul u_k2r4 (.clk(clk), .adv(adv), .a(k2e), .b(r4), .y(k2r4));

    rtp_delay #(.W(FX_W), .DEPTH(2)) u_fd1_d (.clk(clk), .rst_n(rst_n), .adv(adv),
        .d(fd1_reg), .q(fd1_d));

    rtp_smul u_k3r6 (.clk(clk), .adv(adv), .a(k3e), .b(r6), .y(k3r6));

    rtp_delay #(.W(FX_W), .DEPTH(2)) u_fd2_d (.clk(clk), .rst_n(rst_n), .adv(adv),
        .d(fd2_reg), .q(fd2_d));

    // a zero k3 drops the sixth-order term and its overflow
    assign fd_next = (k3_reg != 32'd0) ? fx_add(fd2_d, k3r6) : fd2_d;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fd1_reg <= fx_add(one, k1r2);
            fd2_reg <= fx_add(fd1_d, k2r4);
            fd_reg  <= fd_next;
            xd1_reg <= fx_add(xnfd, p1xy_d);
            yd1_reg <= fx_add(ynfd, p2xy_d);
            xd_reg  <= fx_add(xd1_reg, p2t_d);
            yd_reg  <= fx_add(yd1_reg, p1t_d);
        end
    end

    rtp_delay #(.W(FX_W), .DEPTH(14)) u_xn_d (.clk(clk), .rst_n(rst_n), .adv(adv),
        .d(xn_reg), .q(xn_d));
    rtp_delay #(.W(FX_W), .DEPTH(14)) u_yn_d (.clk(clk), .rst_n(rst_n), .adv(adv),
        .d(yn_reg), .q(yn_d));

    rtp_smul u_xnfd (.clk(clk), .adv(adv), .a(xn_d), .b(fd_reg), .y(xnfd));
    rtp_smul u_ynfd (.clk(clk), .adv(adv), .a(yn_d), .b(fd_reg), .y(ynfd));

    rtp_delay #(.W(FX_W), .DEPTH(11)) u_p1xy_d (.clk(clk), .rst_n(rst_n), .adv(adv),
        .d(p1xy), .q(p1xy_d));
    rtp_delay #(.W(FX_W), .DEPTH(11)) u_p2xy_d (.clk(clk), .rst_n(rst_n), .adv(adv),
        .d(p2xy), .q(p2xy_d));
    rtp_delay #(.W(FX_W), .DEPTH(10)) u_p2t_d (.clk(clk), .rst_n(rst_n), .adv(adv),
        .d(p2t), .q(p2t_d));
    rtp_delay #(.W(FX_W), .DEPTH(10)) u_p1t_d (.clk(clk), .rst_n(rst_n), .adv(adv),
        .d(p1t), .q(p1t_d));

    rtp_smul u_u0 (.clk(clk), .adv(adv), .a(fxe), .b(xd_reg), .y(u0));
    rtp_smul u_v0 (.clk(clk), .adv(adv), .a(fye), .b(yd_reg), .y(v0));

    // final stage: principal point, clamp, status
    fx_t    uc, vc;
    pixel_t fin_next, fin_data_reg;
    logic   fin_valid_reg;

    always_comb
    begin
        uc = fx_clamp32(fx_add(u0, cxe));
        vc = fx_clamp32(fx_add(v0, cye));
        fin_next.pixel_u     = uc.val[31:0];
        fin_next.pixel_v     = vc.val[31:0];
        fin_next.proj_status = (uc.sat | vc.sat) ? ST_SAT : ST_OK;
        if (flag_end[0])
        begin
            fin_next.pixel_u     = '0;
            fin_next.pixel_v     = '0;
            fin_next.proj_status = ST_DEPTH;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            fin_valid_reg <= flag_end[1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fin_data_reg <= fin_next;
        end
    end

    // output register with skid entry; hold the pipeline while the skid is full
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || pixel.ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= fin_valid_reg;
            end
        end
        else if (fin_valid_reg && adv)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || pixel.ready)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : fin_data_reg;
        end
        else if (fin_valid_reg && adv)
        begin
            skid_data_reg <= fin_data_reg;
        end
    end

    assign pixel.valid = out_valid_reg;
    assign pixel.data  = out_data_reg;

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held while output register empty");

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !pixel.ready && fin_valid_reg && !skid_valid_reg)
        |=> (skid_valid_reg && out_valid_reg))
        else $error("stalled beat not captured in skid entry");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg.proj_status != ST_RSVD))
        else $error("reserved status code on output");

    a_depth_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.proj_status == ST_DEPTH)
        |-> (out_data_reg.pixel_u == 32'sd0 && out_data_reg.pixel_v == 32'sd0))
        else $error("non-positive depth beat with nonzero pixel");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import rtp_pkg::*;

    localparam int  TAIL_CYCLES = 120;
    localparam int  CYCLE_LIMIT = 600000;

    logic clk;
    logic rst_n;

    rtp_point_if point_ch ();
    rtp_pixel_if pixel_ch ();
    rtp_cfg_if   cfg_ch ();

    radtan_point_projection dut (
        .clk   (clk),
        .rst_n (rst_n),
        .point (point_ch.sink),
        .pixel (pixel_ch.source),
        .cfg   (cfg_ch.sink)
    );

    // lens settings as held by the block
    logic [31:0] lens_fx;
    logic [31:0] lens_fy;
    logic [63:0] lens_pp;
    logic [31:0] lens_k1;
    logic [31:0] lens_k2;
    logic [31:0] lens_k3;
    logic [31:0] lens_p1;
    logic [31:0] lens_p2;

    pixel_t      pending_pixels[$];
    int          mismatches = 0;
    int          cycle_count = 0;
    bit          gaps_enabled;
    int          stall_left = 0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic signed [63:0] mul_q(input logic signed [63:0] a,
                                                 input logic signed [63:0] b,
                                                 input int                 shift,
                                                 inout bit                 sat);
        logic [63:0]  ua;
        logic [63:0]  ub;
        logic [127:0] prod;
        logic [127:0] mag;
        logic [63:0]  res;
        ua = a[63] ? (~a + 64'd1) : a;
        ub = b[63] ? (~b + 64'd1) : b;
        prod = ua * ub;
        prod = prod + (128'd1 << (shift - 1));
        mag = prod >> shift;
        if (mag > 128'h7FFF_FFFF_FFFF_FFFF)
        begin
            sat = 1'b1;
            mag = 128'h7FFF_FFFF_FFFF_FFFF;
        end
        res = mag[63:0];
        if (a[63] != b[63])
            res = ~res + 64'd1;
        return res;
    endfunction

    function automatic logic signed [63:0] add_q(input logic signed [63:0] a,
                                                 input logic signed [63:0] b,
                                                 inout bit                 sat);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF)
        begin
            sat = 1'b1;
            return FX_MAX;
        end
        if (s < -65'sh0_8000_0000_0000_0000)
        begin
            sat = 1'b1;
            return FX_MIN;
        end
        return s[63:0];
    endfunction

    function automatic logic signed [63:0] clamp_i32(input logic signed [63:0] v,
                                                     inout bit                 sat);
        if (v > I32_MAX)
        begin
            sat = 1'b1;
            return I32_MAX;
        end
        if (v < I32_MIN)
        begin
            sat = 1'b1;
            return I32_MIN;
        end
        return v;
    endfunction

    function automatic logic signed [63:0] norm_q(input logic signed [63:0] num,
                                                  input logic signed [63:0] den);
        logic [63:0] n;
        logic [63:0] q;
        n = (num < 0 ? -num : num) << FRAC;
        q = (n + den / 2) / den;
        return (num < 0) ? -$signed(q) : $signed(q);
    endfunction

    function automatic pixel_t project_point(input point_t p);
        pixel_t             r;
        bit                 sat;
        logic signed [63:0] k1, k2, k3, p1, p2;
        logic signed [63:0] xn, yn, x2, y2, xy, r2, r4, fd, xd, yd, u, v, t;
        logic signed [63:0] m, w;
        sat = 1'b0;
        if (p.point_z <= 0)
        begin
            r.pixel_u = '0;
            r.pixel_v = '0;
            r.proj_status = ST_DEPTH;
            return r;
        end
        k1 = $signed(lens_k1);
        k2 = $signed(lens_k2);
        k3 = $signed(lens_k3);
        p1 = $signed(lens_p1);
        p2 = $signed(lens_p2);
        xn = norm_q(p.point_x, p.point_z);
        yn = norm_q(p.point_y, p.point_z);
        x2 = mul_q(xn, xn, FRAC, sat);
        y2 = mul_q(yn, yn, FRAC, sat);
        xy = mul_q(xn, yn, FRAC, sat);
        r2 = add_q(x2, y2, sat);
        r4 = mul_q(r2, r2, FRAC, sat);
        fd = FX_ONE;
        m = mul_q(k1, r2, FRAC, sat);
        fd = add_q(fd, m, sat);
        m = mul_q(k2, r4, FRAC, sat);
        fd = add_q(fd, m, sat);
        if (k3 != 0)
        begin
            w = mul_q(r4, r2, FRAC, sat);
            m = mul_q(k3, w, FRAC, sat);
            fd = add_q(fd, m, sat);
        end
        xd = mul_q(xn, fd, FRAC, sat);
        m = mul_q(2 * p1, xy, FRAC, sat);
        xd = add_q(xd, m, sat);
        w = add_q(x2, x2, sat);
        t = add_q(r2, w, sat);
        m = mul_q(p2, t, FRAC, sat);
        xd = add_q(xd, m, sat);
        yd = mul_q(yn, fd, FRAC, sat);
        m = mul_q(2 * p2, xy, FRAC, sat);
        yd = add_q(yd, m, sat);
        w = add_q(y2, y2, sat);
        t = add_q(r2, w, sat);
        m = mul_q(p1, t, FRAC, sat);
        yd = add_q(yd, m, sat);
        u = mul_q({32'd0, lens_fx}, xd, FRAC, sat);
        w = add_q(u, {32'd0, lens_pp[63:32]}, sat);
        u = clamp_i32(w, sat);
        v = mul_q({32'd0, lens_fy}, yd, FRAC, sat);
        w = add_q(v, {32'd0, lens_pp[31:0]}, sat);
        v = clamp_i32(w, sat);
        r.pixel_u = u[31:0];
        r.pixel_v = v[31:0];
        r.proj_status = sat ? ST_SAT : ST_OK;
        return r;
    endfunction

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[radtan_point_projection] ERROR");
            $finish;
        end
    end

    // receiver: random stall bursts, check each beat against the oldest prediction
    always @(posedge clk)
    begin
        pixel_t want;
        if (rst_n)
        begin
            if (pixel_ch.valid && pixel_ch.ready)
            begin
                if (pending_pixels.size() == 0)
                begin
                    mismatches++;
                    $display("%0t unexpected pixel beat u=%h v=%h st=%0d", $time,
                             pixel_ch.data.pixel_u, pixel_ch.data.pixel_v,
                             pixel_ch.data.proj_status);
                end
                else
                begin
                    want = pending_pixels.pop_front();
                    if (want.pixel_u !== pixel_ch.data.pixel_u)
                    begin
                        mismatches++;
                        $display("%0t pixel_u expected %h actual %h", $time,
                                 want.pixel_u, pixel_ch.data.pixel_u);
                    end
                    if (want.pixel_v !== pixel_ch.data.pixel_v)
                    begin
                        mismatches++;
                        $display("%0t pixel_v expected %h actual %h", $time,
                                 want.pixel_v, pixel_ch.data.pixel_v);
                    end
                    if (want.proj_status !== pixel_ch.data.proj_status)
                    begin
                        mismatches++;
                        $display("%0t proj_status expected %0d actual %0d", $time,
                                 want.proj_status, pixel_ch.data.proj_status);
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                pixel_ch.ready <= 1'b0;
            end
            else if (gaps_enabled && $urandom_range(0, 5) == 0)
            begin
                stall_left <= $urandom_range(0, 15);
                pixel_ch.ready <= 1'b0;
            end
            else
                pixel_ch.ready <= 1'b1;
        end
        else
            pixel_ch.ready <= 1'b0;
    end

    task automatic send_point(input point_t p);
        if (gaps_enabled && $urandom_range(0, 5) == 0)
        begin
            point_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        point_ch.valid <= 1'b1;
        point_ch.data <= p;
        do
            @(posedge clk);
        while (!point_ch.ready);
        pending_pixels.push_back(project_point(p));
    endtask

    task automatic end_burst();
        point_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        end_burst();
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        case (idx)
            CFG_FOCAL_X: lens_fx = value[31:0];
            CFG_FOCAL_Y: lens_fy = value[31:0];
            CFG_PRINC:   lens_pp = value;
            CFG_K1:      lens_k1 = value[31:0];
            CFG_K2:      lens_k2 = value[31:0];
            CFG_K3:      lens_k3 = value[31:0];
            CFG_P1:      lens_p1 = value[31:0];
            default:     lens_p2 = value[31:0];
        endcase
        @(posedge clk);
    endtask

    task automatic write_lens(input logic [31:0] fx, input logic [31:0] fy,
                              input logic [63:0] pp, input logic [31:0] k1,
                              input logic [31:0] k2, input logic [31:0] k3,
                              input logic [31:0] p1, input logic [31:0] p2);
        write_reg(CFG_FOCAL_X, {32'd0, fx});
        write_reg(CFG_FOCAL_Y, {32'd0, fy});
        write_reg(CFG_PRINC, pp);
        write_reg(CFG_K1, {32'd0, k1});
        write_reg(CFG_K2, {32'd0, k2});
        write_reg(CFG_K3, {32'd0, k3});
        write_reg(CFG_P1, {32'd0, p1});
        write_reg(CFG_P2, {32'd0, p2});
    endtask

    function automatic point_t mk_point(input longint x, input longint y, input longint z);
        point_t p;
        p.point_x = x[31:0];
        p.point_y = y[31:0];
        p.point_z = z[31:0];
        return p;
    endfunction

    function automatic logic [31:0] small_coeff(input int span);
        return $urandom_range(0, 2 * span) - span;
    endfunction

    // mostly points in front of the camera inside a sensible field of view
    function automatic point_t random_point();
        longint z;
        longint x;
        longint y;
        case ($urandom_range(0, 9))
            0:
                return mk_point($urandom, $urandom, $urandom);
            1:
                return mk_point($urandom, $urandom, -longint'($urandom_range(0, 1 << 20)));
            2:
            begin
                z = $urandom_range(1, 1 << 12);
                return mk_point($urandom, $urandom, z);
            end
            default:
            begin
                z = $urandom_range(1 << 14, 64 << 16);
                x = longint'($urandom_range(0, 2 * z)) - z;
                y = longint'($urandom_range(0, 2 * z)) - z;
                return mk_point(x, y, z);
            end
        endcase
    endfunction

    task automatic run_random(input int count);
        for (int i = 0; i < count; i++)
            send_point(random_point());
    endtask

    task automatic randomise_camera();
        write_lens(($urandom_range(50, 2000) << 16) | $urandom_range(0, 65535),
                   ($urandom_range(50, 2000) << 16) | $urandom_range(0, 65535),
                   {$urandom_range(0, 2000) << 16, $urandom_range(0, 2000) << 16},
                   small_coeff(1 << 27), small_coeff(1 << 26),
                   ($urandom_range(0, 1) == 0) ? 32'd0 : small_coeff(1 << 25),
                   small_coeff(1 << 22), small_coeff(1 << 22));
    endtask

    task automatic test_reset_lens();
        send_point(mk_point(0, 0, 1 << 16));
        send_point(mk_point(1 << 16, -(1 << 16), 2 << 16));
        send_point(mk_point(32'h7FFF_FFFF, -32'sh8000_0000, 32'h7FFF_FFFF));
        send_point(mk_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1));
        send_point(mk_point(-32'sh8000_0000, -32'sh8000_0000, 1));
        drain();
    endtask

    task automatic test_depth();
        send_point(mk_point(5 << 16, 5 << 16, 0));
        send_point(mk_point(5 << 16, 5 << 16, -1));
        send_point(mk_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, -32'sh8000_0000));
        send_point(mk_point(0, 0, 1));
        drain();
    endtask

    task automatic test_lens_extremes();
        write_lens(32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                   32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                   32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_point(mk_point(0, 0, 1 << 16));
        send_point(mk_point(1 << 16, 1 << 16, 1 << 16));
        send_point(mk_point(-(1 << 16), 1 << 12, 4 << 16));
        send_point(mk_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1));
        drain();
        write_lens(32'd0, 32'd0, 64'd0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                   32'h8000_0000, 32'h8000_0000);
        send_point(mk_point(1 << 16, -(1 << 16), 1 << 16));
        send_point(mk_point(3 << 15, 1 << 14, 1 << 16));
        drain();
        write_lens(500 << 16, 500 << 16, {32'd320 << 16, 32'd240 << 16},
                   32'hF800_0000, 32'h0200_0000, 32'd0, 32'h0010_0000, 32'hFFF0_0000);
        send_point(mk_point(1 << 16, 1 << 16, 1 << 16));
        send_point(mk_point(-(3 << 16), 2 << 16, 5 << 16));
        drain();
    endtask

    task automatic test_random_cameras();
        for (int phase = 0; phase < 6; phase++)
        begin
            randomise_camera();
            run_random(150);
            if (phase == 2)
                drain();
            run_random(100);
            drain();
        end
        gaps_enabled = 1'b1;
        write_lens(32'hFFFF_FFFF, 32'h0000_0001, 64'h8000_0000_0000_0001,
                   32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 32'h8000_0000, 32'h7FFF_FFFF);
        run_random(100);
        drain();
    endtask

    task automatic test_no_gaps();
        gaps_enabled = 1'b0;
        randomise_camera();
        run_random(230);
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        gaps_enabled = 1'b1;
        point_ch.valid <= 1'b0;
        point_ch.data <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= CFG_FOCAL_X;
        cfg_ch.data <= '0;
        lens_fx = FOCAL_RESET;
        lens_fy = FOCAL_RESET;
        lens_pp = '0;
        lens_k1 = '0;
        lens_k2 = '0;
        lens_k3 = '0;
        lens_p1 = '0;
        lens_p2 = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_lens();
        test_depth();
        test_lens_extremes();
        test_random_cameras();
        test_no_gaps();

        if (mismatches == 0)
            $display("[radtan_point_projection] OK");
        else
            $display("[radtan_point_projection] ERROR");
        $finish;
    end

endmodule
